[rtl/quadratic_root_solver_core_defines.svh]
// Assertion macros for the quadratic root solver core.
// Used by quadratic_root_solver_core.sv; expects i_clk and i_rst_n in scope.
`ifndef QUADRATIC_ROOT_SOLVER_CORE_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define QRS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("qrs assertion failed");

// next-cycle implication, checked out of reset
`define QRS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("qrs assertion failed");

`endif

[rtl/qrs_pkg.sv]
// Shared types and codes of the quadratic root solver.
// No dependencies.
`timescale 1ns / 1ps

package qrs_pkg;

    localparam int ROOT_OUT_W = 64;

    // root kind
    localparam logic [1:0] K_REAL = 2'd0;
    localparam logic [1:0] K_CPLX = 2'd1;
    localparam logic [1:0] K_NONE = 2'd2;

    // status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZLEAD = 2'd1;
    localparam logic [1:0] ST_SAT   = 2'd2;

    // solve mode carried down the pipeline
    localparam logic [2:0] M_NONE  = 3'd0;
    localparam logic [2:0] M_ERR   = 3'd1;
    localparam logic [2:0] M_ZERO  = 3'd2;
    localparam logic [2:0] M_LIN   = 3'd3;
    localparam logic [2:0] M_QUAD  = 3'd4;
    localparam logic [2:0] M_DBL   = 3'd5;
    localparam logic [2:0] M_REAL2 = 3'd6;
    localparam logic [2:0] M_CPLX  = 3'd7;

    typedef struct packed {
        logic [2:0] mode;
        logic [1:0] zm;
        logic       n0;
        logic       n1;
        logic       n2;
    } t_ctl;

    typedef struct packed {
        logic [ROOT_OUT_W-1:0] re;
        logic [ROOT_OUT_W-1:0] im;
        logic [1:0]            mult;
        logic [1:0]            kind;
        logic [1:0]            status;
        logic                  last;
    } t_res;

endpackage

[rtl/qrs_sqrt_pipe.sv]
// Pipelined integer square root, one root bit per stage, of i_rad * 2^(2*FRAC).
// Standalone; sideband bits travel with each beat.
`timescale 1ns / 1ps

module qrs_sqrt_pipe #(
    parameter int DW     = 65,
    parameter int FRAC   = 32,
    parameter int SIDE_W = 8,
    localparam int SW    = (DW + 2 * FRAC + 1) / 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [DW-1:0]     i_rad,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [SW-1:0]     o_root,
    output logic [SIDE_W-1:0] o_side
);

    localparam int XW  = 2 * SW;
    localparam int RMW = SW + 2;

    logic              r_v    [SW];
    logic [RMW-1:0]    r_rem  [SW];
    logic [SW-1:0]     r_root [SW];
    logic [DW-1:0]     r_rad  [SW];
    logic [SIDE_W-1:0] r_side [SW];

    for (genvar g = 0; g < SW; g++) begin : g_stage
        logic              p_v;
        logic [RMW-1:0]    p_rem;
        logic [SW-1:0]     p_root;
        logic [DW-1:0]     p_rad;
        logic [SIDE_W-1:0] p_side;
        logic [XW-1:0]     x;
        logic [RMW+1:0]    cat;
        logic [RMW+1:0]    trial;
        logic              take;
        logic [RMW-1:0]    n_rem;
        logic [SW-1:0]     n_root;

        if (g == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_rad  = i_rad;
            assign p_side = i_side;
        end else begin : g_next
            assign p_v    = r_v[g-1];
            assign p_rem  = r_rem[g-1];
            assign p_root = r_root[g-1];
            assign p_rad  = r_rad[g-1];
            assign p_side = r_side[g-1];
        end

        always_comb begin
            x      = XW'(p_rad) << (2 * FRAC);
            cat    = {p_rem, x[2*(SW-1-g) +: 2]};
            trial  = (RMW+2)'({p_root, 2'b01});
            take   = (cat >= trial);
            n_rem  = take ? RMW'(cat - trial) : RMW'(cat);
            n_root = {p_root[SW-2:0], take};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_rad[g]  <= p_rad;
                r_side[g] <= p_side;
            end
        end
    end

    assign o_valid = r_v[SW-1];
    assign o_root  = r_root[SW-1];
    assign o_side  = r_side[SW-1];

endmodule

[rtl/qrs_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, round half away
// from zero, with an overflow flag when the quotient needs more than QW bits.
`timescale 1ns / 1ps

module qrs_div_pipe #(
    parameter int NW     = 97,
    parameter int DNW    = 66,
    parameter int QW     = 65,
    parameter int SIDE_W = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NW-1:0]     i_num,
    input  logic [DNW-1:0]    i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [QW:0]       o_quo,
    output logic              o_ovf,
    output logic [SIDE_W-1:0] o_side
);

    localparam int CMPW = ((NW > DNW + QW) ? NW : DNW + QW) + 1;

    // overflow check and first partial remainder
    logic [CMPW-1:0] c_num;
    logic [CMPW-1:0] c_lim;
    logic            c_ovf;
    logic [DNW-1:0]  c_rem0;

    always_comb begin
        c_num  = CMPW'(i_num);
        c_lim  = CMPW'(i_den) << QW;
        c_ovf  = (c_num >= c_lim);
        c_rem0 = DNW'(c_num >> QW);
    end

    logic              r_pv;
    logic [DNW-1:0]    r_prem;
    logic [QW-1:0]     r_pbits;
    logic [DNW-1:0]    r_pden;
    logic              r_povf;
    logic [SIDE_W-1:0] r_pside;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (i_en) begin
            r_pv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prem  <= c_rem0;
            r_pbits <= QW'(c_num);
            r_pden  <= i_den;
            r_povf  <= c_ovf;
            r_pside <= i_side;
        end
    end

    logic              r_v    [QW];
    logic [DNW-1:0]    r_rem  [QW];
    logic [QW-1:0]     r_q    [QW];
    logic [QW-1:0]     r_bits [QW];
    logic [DNW-1:0]    r_den  [QW];
    logic              r_ovf  [QW];
    logic [SIDE_W-1:0] r_side [QW];

    for (genvar g = 0; g < QW; g++) begin : g_stage
        logic              p_v;
        logic [DNW-1:0]    p_rem;
        logic [QW-1:0]     p_q;
        logic [QW-1:0]     p_bits;
        logic [DNW-1:0]    p_den;
        logic              p_ovf;
        logic [SIDE_W-1:0] p_side;
        logic [DNW:0]      cat;
        logic              take;
        logic [DNW-1:0]    n_rem;

        if (g == 0) begin : g_first
            assign p_v    = r_pv;
            assign p_rem  = r_prem;
            assign p_q    = '0;
            assign p_bits = r_pbits;
            assign p_den  = r_pden;
            assign p_ovf  = r_povf;
            assign p_side = r_pside;
        end else begin : g_next
            assign p_v    = r_v[g-1];
            assign p_rem  = r_rem[g-1];
            assign p_q    = r_q[g-1];
            assign p_bits = r_bits[g-1];
            assign p_den  = r_den[g-1];
            assign p_ovf  = r_ovf[g-1];
            assign p_side = r_side[g-1];
        end

        always_comb begin
            cat   = {p_rem, p_bits[QW-1]};
            take  = (cat >= {1'b0, p_den});
            n_rem = take ? DNW'(cat - {1'b0, p_den}) : DNW'(cat);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g] <= 1'b0;
            end else if (i_en) begin
                r_v[g] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= n_rem;
                r_q[g]    <= {p_q[QW-2:0], take};
                r_bits[g] <= p_bits << 1;
                r_den[g]  <= p_den;
                r_ovf[g]  <= p_ovf;
                r_side[g] <= p_side;
            end
        end
    end

    // round: add one when twice the remainder reaches the divisor
    logic              c_up;
    logic              r_ov;
    logic [QW:0]       r_quo;
    logic              r_oovf;
    logic [SIDE_W-1:0] r_oside;

    assign c_up = ({r_rem[QW-1], 1'b0} >= {1'b0, r_den[QW-1]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_v[QW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo   <= (QW+1)'(r_q[QW-1]) + (QW+1)'(c_up);
            r_oovf  <= r_ovf[QW-1];
            r_oside <= r_side[QW-1];
        end
    end

    assign o_valid = r_ov;
    assign o_quo   = r_quo;
    assign o_ovf   = r_oovf;
    assign o_side  = r_oside;

endmodule

[rtl/quadratic_root_solver_core.sv]
// Quadratic root solver core: stable-formula roots of a degree 0..2 polynomial.
// Depends on qrs_pkg, qrs_sqrt_pipe, qrs_div_pipe and the core defines header.
//
// Usage:
//   Input channel (i_valid / o_stall) carries one polynomial per beat: degree
//   and three signed coefficients, leading first. Output channel (o_valid /
//   i_stall) carries one root per beat; a polynomial yields one or two beats,
//   the final one flagged by o_last_root.
//   Pipeline: four front stages form the magnitudes, split products and
//   discriminant; the square root takes one stage per root bit, then both
//   dividers take one stage per quotient bit.
//   Throughput: one polynomial per cycle when it gives one result and the
//   output is not stalled; a polynomial with two results holds the pipeline
//   while its second beat goes out.
//   Stall: the whole pipeline advances on one enable. When the output beat
//   is stalled (or the second beat of a pair is pending) every stage holds
//   and o_stall is raised; no beat is dropped or repeated.
//   Reset (synchronous, active low) clears every valid bit; the block
//   accepts a beat in the first cycle after reset.
`timescale 1ns / 1ps
`include "quadratic_root_solver_core_defines.svh"

module quadratic_root_solver_core
    import qrs_pkg::*;
#(
    parameter int COEF_WIDTH = 32,
    parameter int ROOT_WIDTH = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_poly_degree,
    input  logic [COEF_WIDTH-1:0] i_coef_lead,
    input  logic [COEF_WIDTH-1:0] i_coef_mid,
    input  logic [COEF_WIDTH-1:0] i_coef_const,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [ROOT_OUT_W-1:0] o_root_real,
    output logic [ROOT_OUT_W-1:0] o_root_imag,
    output logic [1:0]            o_multiplicity,
    output logic [1:0]            o_root_kind,
    output logic [1:0]            o_status,
    output logic                  o_last_root
);

    localparam int CW     = COEF_WIDTH;
    localparam int RW     = ROOT_WIDTH;
    localparam int F      = RW / 2;
    localparam int H      = (CW + 1) / 2;
    localparam int HI     = CW - H;
    localparam int DW     = 2 * CW + 1;
    localparam int SW     = (DW + 2 * F + 1) / 2;
    localparam int NW     = ((CW + 2 * F + 1) > (SW + 2)) ? (CW + 2 * F + 1) : (SW + 2);
    localparam int DNW    = (((CW + F) > SW) ? (CW + F) : SW) + 1;
    localparam int QW     = RW + 1;
    localparam int CTL_W  = $bits(t_ctl);
    localparam int SIDE_W = CTL_W + 3 * CW;

    // global advance; every stage moves together
    logic en;

    function automatic logic [CW-1:0] f_mag(input logic [CW-1:0] raw);
        f_mag = raw[CW-1] ? (~raw + CW'(1)) : raw;
    endfunction

    // saturate a rounded magnitude to RW signed bits: {sat, value}
    function automatic logic [RW:0] f_sat(input logic [QW:0] mag, input logic ovf,
                                          input logic neg);
        logic [QW:0]   lim;
        logic          sat;
        logic [QW:0]   v;
        logic [RW-1:0] val;
        lim = (QW+1)'(1) << (RW - 1);
        if (!neg) begin
            lim = lim - (QW+1)'(1);
        end
        sat   = ovf || (mag > lim);
        v     = sat ? lim : mag;
        val   = neg ? (RW'(0) - v[RW-1:0]) : v[RW-1:0];
        f_sat = {sat, val};
    endfunction

    // ---------------- stage 1: magnitudes and signs ----------------
    logic          r_s1_v;
    logic [1:0]    r_s1_deg;
    logic [CW-1:0] r_s1_m0, r_s1_m1, r_s1_m2;
    logic          r_s1_n0, r_s1_n1, r_s1_n2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (en) begin
            r_s1_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // degree three is solved as degree two
            r_s1_deg <= (i_poly_degree == 2'd3) ? 2'd2 : i_poly_degree;
            r_s1_m0  <= f_mag(i_coef_lead);
            r_s1_m1  <= f_mag(i_coef_mid);
            r_s1_m2  <= f_mag(i_coef_const);
            r_s1_n0  <= i_coef_lead[CW-1];
            r_s1_n1  <= i_coef_mid[CW-1];
            r_s1_n2  <= i_coef_const[CW-1];
        end
    end

    // ---------------- stage 2: classify, split products ----------------
    t_ctl c_s2_ctl;

    always_comb begin
        c_s2_ctl.n0   = r_s1_n0;
        c_s2_ctl.n1   = r_s1_n1;
        c_s2_ctl.n2   = r_s1_n2;
        c_s2_ctl.zm   = 2'd0;
        c_s2_ctl.mode = M_QUAD;
        if (r_s1_deg == 2'd0) begin
            c_s2_ctl.mode = M_NONE;
        end else if (r_s1_m0 == '0) begin
            c_s2_ctl.mode = M_ERR;
        end else if (r_s1_deg == 2'd1) begin
            if (r_s1_m1 == '0) begin
                c_s2_ctl.zm   = 2'd1;
                c_s2_ctl.mode = M_ZERO;
            end else begin
                c_s2_ctl.mode = M_LIN;
            end
        end else if (r_s1_m2 == '0) begin
            // trailing zero coefficients give the zero root first
            if (r_s1_m1 == '0) begin
                c_s2_ctl.zm   = 2'd2;
                c_s2_ctl.mode = M_ZERO;
            end else begin
                c_s2_ctl.zm   = 2'd1;
                c_s2_ctl.mode = M_LIN;
            end
        end
    end

    logic              r_s2_v;
    t_ctl              r_s2_ctl;
    logic [CW-1:0]     r_s2_m0, r_s2_m1, r_s2_m2;
    logic [2*H-1:0]    r_bb_ll, r_ac_ll;
    logic [H+HI-1:0]   r_bb_lh, r_ac_lh, r_ac_hl;
    logic [2*HI-1:0]   r_bb_hh, r_ac_hh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (en) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_ctl <= c_s2_ctl;
            r_s2_m0  <= r_s1_m0;
            r_s2_m1  <= r_s1_m1;
            r_s2_m2  <= r_s1_m2;
            r_bb_ll  <= (2*H)'(r_s1_m1[H-1:0]) * (2*H)'(r_s1_m1[H-1:0]);
            r_bb_lh  <= (H+HI)'(r_s1_m1[H-1:0]) * (H+HI)'(r_s1_m1[CW-1:H]);
            r_bb_hh  <= (2*HI)'(r_s1_m1[CW-1:H]) * (2*HI)'(r_s1_m1[CW-1:H]);
            r_ac_ll  <= (2*H)'(r_s1_m0[H-1:0]) * (2*H)'(r_s1_m2[H-1:0]);
            r_ac_lh  <= (H+HI)'(r_s1_m0[H-1:0]) * (H+HI)'(r_s1_m2[CW-1:H]);
            r_ac_hl  <= (H+HI)'(r_s1_m0[CW-1:H]) * (H+HI)'(r_s1_m2[H-1:0]);
            r_ac_hh  <= (2*HI)'(r_s1_m0[CW-1:H]) * (2*HI)'(r_s1_m2[CW-1:H]);
        end
    end

    // ---------------- stage 3: sum partial products ----------------
    logic          r_s3_v;
    t_ctl          r_s3_ctl;
    logic [CW-1:0] r_s3_m0, r_s3_m1, r_s3_m2;
    logic [DW-1:0] r_s3_b2, r_s3_ac;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_v <= 1'b0;
        end else if (en) begin
            r_s3_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s3_ctl <= r_s2_ctl;
            r_s3_m0  <= r_s2_m0;
            r_s3_m1  <= r_s2_m1;
            r_s3_m2  <= r_s2_m2;
            r_s3_b2  <= (DW'(r_bb_hh) << (2 * H)) + (DW'(r_bb_lh) << (H + 1))
                        + DW'(r_bb_ll);
            r_s3_ac  <= (DW'(r_ac_hh) << (2 * H))
                        + ((DW'(r_ac_lh) + DW'(r_ac_hl)) << H) + DW'(r_ac_ll);
        end
    end

    // ---------------- stage 4: discriminant ----------------
    logic [DW-1:0] c_ac4, c_dsum, c_dpos, c_dneg, c_rad;
    t_ctl          c_s4_ctl;

    always_comb begin
        c_ac4    = r_s3_ac << 2;
        c_dsum   = r_s3_b2 + c_ac4;
        c_dpos   = r_s3_b2 - c_ac4;
        c_dneg   = c_ac4 - r_s3_b2;
        c_s4_ctl = r_s3_ctl;
        c_rad    = '0;
        if (r_s3_ctl.mode == M_QUAD) begin
            if (r_s3_ctl.n0 ^ r_s3_ctl.n2) begin
                c_rad         = c_dsum;
                c_s4_ctl.mode = M_REAL2;
            end else if (r_s3_b2 == c_ac4) begin
                c_s4_ctl.mode = M_DBL;
            end else if (r_s3_b2 > c_ac4) begin
                c_rad         = c_dpos;
                c_s4_ctl.mode = M_REAL2;
            end else begin
                c_rad         = c_dneg;
                c_s4_ctl.mode = M_CPLX;
            end
        end
    end

    logic          r_s4_v;
    t_ctl          r_s4_ctl;
    logic [CW-1:0] r_s4_m0, r_s4_m1, r_s4_m2;
    logic [DW-1:0] r_s4_rad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_v <= 1'b0;
        end else if (en) begin
            r_s4_v <= r_s3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_ctl <= c_s4_ctl;
            r_s4_m0  <= r_s3_m0;
            r_s4_m1  <= r_s3_m1;
            r_s4_m2  <= r_s3_m2;
            r_s4_rad <= c_rad;
        end
    end

    // ---------------- square root ----------------
    logic              sq_v;
    logic [SW-1:0]     sq_root;
    logic [SIDE_W-1:0] sq_side;

    qrs_sqrt_pipe #(
        .DW     (DW),
        .FRAC   (F),
        .SIDE_W (SIDE_W)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_s4_v),
        .i_rad   (r_s4_rad),
        .i_side  ({r_s4_ctl, r_s4_m0, r_s4_m1, r_s4_m2}),
        .o_valid (sq_v),
        .o_root  (sq_root),
        .o_side  (sq_side)
    );

    // ---------------- divider setup ----------------
    t_ctl           c_p_ctl;
    logic [CW-1:0]  c_p_m0, c_p_m1, c_p_m2;
    logic [DNW-1:0] c_q2, c_twoa, c_da, c_db;
    logic [NW-1:0]  c_m1f, c_na, c_nb;

    always_comb begin
        {c_p_ctl, c_p_m0, c_p_m1, c_p_m2} = sq_side;
        c_q2   = (DNW'(c_p_m1) << F) + DNW'(sq_root);
        c_twoa = DNW'(c_p_m0) << 1;
        c_m1f  = NW'(c_p_m1) << F;
        c_na   = '0;
        c_da   = DNW'(1);
        c_nb   = '0;
        c_db   = DNW'(1);
        case (c_p_ctl.mode)
            M_LIN: begin
                c_na = c_m1f;
                c_da = DNW'(c_p_m0);
            end
            M_DBL: begin
                c_na = c_m1f;
                c_da = c_twoa;
            end
            M_REAL2: begin
                c_na = NW'(c_q2);
                c_da = c_twoa;
                c_nb = NW'(c_p_m2) << (2 * F + 1);
                c_db = c_q2;
            end
            M_CPLX: begin
                c_na = c_m1f;
                c_da = c_twoa;
                c_nb = NW'(sq_root);
                c_db = c_twoa;
            end
            default: ;
        endcase
    end

    logic           r_p_v;
    t_ctl           r_p_ctl;
    logic [NW-1:0]  r_p_na, r_p_nb;
    logic [DNW-1:0] r_p_da, r_p_db;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (en) begin
            r_p_v <= sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_ctl <= c_p_ctl;
            r_p_na  <= c_na;
            r_p_nb  <= c_nb;
            r_p_da  <= c_da;
            r_p_db  <= c_db;
        end
    end

    // ---------------- dividers ----------------
    logic             dv_v;
    logic [QW:0]      dv_qa, dv_qb;
    logic             dv_ovfa, dv_ovfb;
    logic [CTL_W-1:0] dv_side;

    qrs_div_pipe #(
        .NW     (NW),
        .DNW    (DNW),
        .QW     (QW),
        .SIDE_W (CTL_W)
    ) u_div_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_p_v),
        .i_num   (r_p_na),
        .i_den   (r_p_da),
        .i_side  (r_p_ctl),
        .o_valid (dv_v),
        .o_quo   (dv_qa),
        .o_ovf   (dv_ovfa),
        .o_side  (dv_side)
    );

    qrs_div_pipe #(
        .NW     (NW),
        .DNW    (DNW),
        .QW     (QW),
        .SIDE_W (1)
    ) u_div_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_p_v),
        .i_num   (r_p_nb),
        .i_den   (r_p_db),
        .i_side  (1'b0),
        .o_valid (),
        .o_quo   (dv_qb),
        .o_ovf   (dv_ovfb),
        .o_side  ()
    );

    // ---------------- result assembly ----------------
    t_ctl                  c_ctl;
    logic                  c_halfneg, c_qneg, c_nega, c_negb;
    logic [RW:0]           c_sa, c_sb, c_sc;
    logic [ROOT_OUT_W-1:0] c_va, c_vb, c_vc;
    t_res                  c_zero, c_ra, c_r0, c_r1;
    logic                  c_two;

    always_comb begin
        c_ctl     = dv_side;
        c_halfneg = !(c_ctl.n1 ^ c_ctl.n0);
        c_qneg    = !c_ctl.n1;
        c_nega    = (c_ctl.mode == M_REAL2) ? (c_qneg ^ c_ctl.n0) : c_halfneg;
        c_negb    = (c_ctl.mode == M_REAL2) ? (c_qneg ^ c_ctl.n2) : (c_qneg ^ c_ctl.n0);
        c_sa      = f_sat(dv_qa, dv_ovfa, c_nega);
        c_sb      = f_sat(dv_qb, dv_ovfb, c_negb);
        // conjugate: same magnitude, opposite sign, own saturation limit
        c_sc      = f_sat(dv_qb, dv_ovfb, !c_negb);
        c_va      = ROOT_OUT_W'($signed(c_sa[RW-1:0]));
        c_vb      = ROOT_OUT_W'($signed(c_sb[RW-1:0]));
        c_vc      = ROOT_OUT_W'($signed(c_sc[RW-1:0]));

        c_zero        = '0;
        c_zero.mult   = c_ctl.zm;
        c_zero.kind   = K_REAL;
        c_zero.status = ST_OK;

        c_ra        = '0;
        c_ra.re     = c_va;
        c_ra.mult   = 2'd1;
        c_ra.kind   = K_REAL;
        c_ra.status = c_sa[RW] ? ST_SAT : ST_OK;
        c_ra.last   = 1'b1;

        c_r0        = '0;
        c_r0.kind   = K_NONE;
        c_r0.status = ST_OK;
        c_r0.last   = 1'b1;
        c_r1        = c_ra;
        c_two       = 1'b0;

        case (c_ctl.mode)
            M_NONE: ;
            M_ERR: begin
                c_r0.status = ST_ZLEAD;
            end
            M_ZERO: begin
                c_r0      = c_zero;
                c_r0.last = 1'b1;
            end
            M_LIN: begin
                if (c_ctl.zm != 2'd0) begin
                    c_r0  = c_zero;
                    c_two = 1'b1;
                end else begin
                    c_r0 = c_ra;
                end
            end
            M_DBL: begin
                c_r0      = c_ra;
                c_r0.mult = 2'd2;
            end
            M_REAL2: begin
                c_r0        = c_ra;
                c_r0.last   = 1'b0;
                c_r1.re     = c_vb;
                c_r1.status = c_sb[RW] ? ST_SAT : ST_OK;
                c_two       = 1'b1;
            end
            M_CPLX: begin
                c_r0.re     = c_va;
                c_r0.im     = c_vb;
                c_r0.mult   = 2'd1;
                c_r0.kind   = K_CPLX;
                c_r0.status = (c_sa[RW] || c_sb[RW]) ? ST_SAT : ST_OK;
                c_r0.last   = 1'b0;
                c_r1        = c_r0;
                c_r1.im     = c_vc;
                c_r1.status = (c_sa[RW] || c_sc[RW]) ? ST_SAT : ST_OK;
                c_r1.last   = 1'b1;
                c_two       = 1'b1;
            end
            default: ;
        endcase
    end

    // ---------------- output hold ----------------
    logic r_hv;
    logic r_idx;
    logic r_two;
    t_res r_r0, r_r1;
    t_res c_out;

    // advance when the hold is empty or its final beat leaves this cycle
    assign en = !r_hv || (!i_stall && (r_idx || !r_two));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hv  <= 1'b0;
            r_idx <= 1'b0;
        end else if (en) begin
            r_hv  <= dv_v;
            r_idx <= 1'b0;
        end else if (!i_stall) begin
            r_idx <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_r0  <= c_r0;
            r_r1  <= c_r1;
            r_two <= c_two;
        end
    end

    assign c_out          = r_idx ? r_r1 : r_r0;
    assign o_valid        = r_hv;
    assign o_stall        = !en;
    assign o_root_real    = c_out.re;
    assign o_root_imag    = c_out.im;
    assign o_multiplicity = c_out.mult;
    assign o_root_kind    = c_out.kind;
    assign o_status       = c_out.status;
    assign o_last_root    = c_out.last;

    // ---------------- checks ----------------
    `QRS_ASSERT_IMP(a_none_last, o_valid && (o_root_kind == K_NONE), o_last_root && (o_multiplicity == 2'd0))
    `QRS_ASSERT_IMP(a_stall_hold, o_stall, o_valid)
    `QRS_ASSERT_NEXT(a_pair_second, o_valid && !i_stall && !o_last_root, o_valid)
    `QRS_ASSERT_IMP(a_cplx_ok, o_valid && (o_root_kind == K_CPLX), (o_status != ST_ZLEAD) && (o_multiplicity == 2'd1))

endmodule

[tb/qrs_root_checker.sv]
// Root checker for quadratic_root_solver_core: watches both channels, predicts
// the roots of each accepted polynomial and compares the result beats in order.
// Depends on qrs_pkg.
`timescale 1ns / 1ps

module qrs_root_checker
    import qrs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_poly_degree,
    input  logic [31:0] i_coef_lead,
    input  logic [31:0] i_coef_mid,
    input  logic [31:0] i_coef_const,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [63:0] i_root_real,
    input  logic [63:0] i_root_imag,
    input  logic [1:0]  i_multiplicity,
    input  logic [1:0]  i_root_kind,
    input  logic [1:0]  i_status,
    input  logic        i_last_root,
    output int          o_pending,
    output int          o_errors
);

    typedef logic [255:0] wide_t;

    t_res roots_q[$];

    initial begin
        o_pending = 0;
        o_errors  = 0;
    end

    function automatic wide_t div_round(wide_t num, wide_t den);
        wide_t quo;
        wide_t rem;
        quo = num / den;
        rem = num % den;
        if ((rem << 1) >= den)
            quo = quo + 1;
        return quo;
    endfunction

    function automatic wide_t isqrt(wide_t x);
        wide_t res;
        wide_t trial;
        res = '0;
        for (int k = 127; k >= 0; k--) begin
            trial = res | (wide_t'(1) << k);
            if (trial * trial <= x)
                res = trial;
        end
        return res;
    endfunction

    // clamp a magnitude to the signed 64-bit range and apply the sign
    function automatic logic [63:0] to_root(wide_t mag, logic neg, inout logic sat);
        wide_t lim;
        logic [63:0] v;
        lim = wide_t'(1) << 63;
        if (!neg)
            lim = lim - 1;
        if (mag > lim) begin
            mag = lim;
            sat = 1'b1;
        end
        v = mag[63:0];
        return neg ? -v : v;
    endfunction

    function automatic t_res make_root(logic [63:0] re, logic [63:0] im, logic [1:0] mult,
                                       logic [1:0] kind, logic [1:0] st, logic last);
        t_res r;
        r.re     = re;
        r.im     = im;
        r.mult   = mult;
        r.kind   = kind;
        r.status = st;
        r.last   = last;
        return r;
    endfunction

    function automatic t_res real_root(wide_t mag, logic neg, logic [1:0] mult, logic last);
        logic sat;
        logic [63:0] re;
        sat = 1'b0;
        re  = to_root(mag, neg, sat);
        return make_root(re, '0, mult, K_REAL, sat ? ST_SAT : ST_OK, last);
    endfunction

    // push the expected root beats of one polynomial
    task automatic predict_roots(logic [1:0] deg_in, logic [31:0] c0, logic [31:0] c1,
                                 logic [31:0] c2);
        logic [31:0] raw [3];
        logic [32:0] mag [3];
        logic        neg [3];
        int          deg;
        int          zm;
        int          dsign;
        logic        qneg;
        logic        halfneg;
        logic        imneg;
        logic        sat1;
        logic        sat2;
        wide_t       b2;
        wide_t       ac4;
        wide_t       dm;
        wide_t       twoa;
        wide_t       s;
        wide_t       q2;
        wide_t       re;
        wide_t       im;
        raw[0] = c0;
        raw[1] = c1;
        raw[2] = c2;
        for (int i = 0; i < 3; i++) begin
            neg[i] = raw[i][31];
            mag[i] = neg[i] ? (33'd0 - {1'b1, raw[i]}) : {1'b0, raw[i]};
        end
        deg = (deg_in > 2) ? 2 : int'(deg_in);
        if (deg == 0) begin
            roots_q.push_back(make_root('0, '0, 2'd0, K_NONE, ST_OK, 1'b1));
            return;
        end
        if (mag[0] == 0) begin
            roots_q.push_back(make_root('0, '0, 2'd0, K_NONE, ST_ZLEAD, 1'b1));
            return;
        end
        zm = 0;
        while (zm < deg && mag[deg - zm] == 0)
            zm++;
        deg = deg - zm;
        if (zm != 0)
            roots_q.push_back(make_root('0, '0, 2'(zm), K_REAL, ST_OK, deg == 0));
        if (deg == 1) begin
            re = div_round(wide_t'(mag[1]) << 32, wide_t'(mag[0]));
            roots_q.push_back(real_root(re, !(neg[1] ^ neg[0]), 2'd1, 1'b1));
        end else if (deg == 2) begin
            qneg    = !neg[1];
            halfneg = !(neg[1] ^ neg[0]);
            b2      = wide_t'(mag[1]) * wide_t'(mag[1]);
            ac4     = (wide_t'(mag[0]) * wide_t'(mag[2])) << 2;
            if (neg[0] ^ neg[2]) begin
                dm    = b2 + ac4;
                dsign = 1;
            end else begin
                dsign = (b2 > ac4) ? 1 : (b2 == ac4) ? 0 : -1;
                dm    = (b2 > ac4) ? b2 - ac4 : ac4 - b2;
            end
            twoa = wide_t'(mag[0]) << 1;
            if (dsign == 0) begin
                re = div_round(wide_t'(mag[1]) << 32, twoa);
                roots_q.push_back(real_root(re, halfneg, 2'd2, 1'b1));
            end else begin
                s = isqrt(dm << 64);
                if (dsign > 0) begin
                    q2 = (wide_t'(mag[1]) << 32) + s;
                    roots_q.push_back(real_root(div_round(q2, twoa), qneg ^ neg[0],
                                                2'd1, 1'b0));
                    roots_q.push_back(real_root(div_round(wide_t'(mag[2]) << 65, q2),
                                                qneg ^ neg[2], 2'd1, 1'b1));
                end else begin
                    imneg = qneg ^ neg[0];
                    sat1  = 1'b0;
                    sat2  = 1'b0;
                    re    = div_round(wide_t'(mag[1]) << 32, twoa);
                    im    = div_round(s, twoa);
                    roots_q.push_back(make_root(to_root(re, halfneg, sat1),
                                                to_root(im, imneg, sat1), 2'd1, K_CPLX,
                                                sat1 ? ST_SAT : ST_OK, 1'b0));
                    roots_q.push_back(make_root(to_root(re, halfneg, sat2),
                                                to_root(im, !imneg, sat2), 2'd1, K_CPLX,
                                                sat2 ? ST_SAT : ST_OK, 1'b1));
                end
            end
        end
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("root mismatch on %s: got %h, expected %h", what, got, want);
        o_errors++;
    endtask

    // compare outgoing beats first, then predict for the incoming polynomial
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n) begin
            if (i_out_valid && !i_out_stall) begin
                if (roots_q.size() == 0) begin
                    report_mismatch("unexpected beat root_real", i_root_real, '0);
                end else begin
                    want = roots_q.pop_front();
                    if (i_root_real !== want.re)
                        report_mismatch("root_real", i_root_real, want.re);
                    if (i_root_imag !== want.im)
                        report_mismatch("root_imag", i_root_imag, want.im);
                    if (i_multiplicity !== want.mult)
                        report_mismatch("multiplicity", 64'(i_multiplicity), 64'(want.mult));
                    if (i_root_kind !== want.kind)
                        report_mismatch("root_kind", 64'(i_root_kind), 64'(want.kind));
                    if (i_status !== want.status)
                        report_mismatch("status", 64'(i_status), 64'(want.status));
                    if (i_last_root !== want.last)
                        report_mismatch("last_root", 64'(i_last_root), 64'(want.last));
                end
            end
            if (i_in_valid && !i_in_stall)
                predict_roots(i_poly_degree, i_coef_lead, i_coef_mid, i_coef_const);
        end
        o_pending = roots_q.size();
    end

endmodule

[tb/tb.sv]
// Top of the quadratic root solver bench: clock, reset, polynomial stimulus,
// output back-pressure and the verdict. Depends on qrs_pkg,
// quadratic_root_solver_core and qrs_root_checker.
`timescale 1ns / 1ps

module tb;
    import qrs_pkg::*;

    localparam int LATENCY    = 138;
    localparam int IDLE_LIMIT = 6000;
    localparam int HOLD_LEN   = 500;
    localparam int N_RANDOM   = 1530;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [1:0]  i_poly_degree = '0;
    logic [31:0] i_coef_lead = '0;
    logic [31:0] i_coef_mid = '0;
    logic [31:0] i_coef_const = '0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [63:0] o_root_real;
    logic [63:0] o_root_imag;
    logic [1:0]  o_multiplicity;
    logic [1:0]  o_root_kind;
    logic [1:0]  o_status;
    logic        o_last_root;

    int   pending;
    int   errors;
    logic quiet = 1'b0;      // no idling on either side while set
    logic hold_req = 1'b0;   // ask the receiver for one long hold-off
    logic hold_armed = 1'b0; // the hold-off has been taken once
    int   idle_cycles = 0;

    always #6 i_clk = ~i_clk;

    quadratic_root_solver_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_poly_degree (i_poly_degree),
        .i_coef_lead   (i_coef_lead),
        .i_coef_mid    (i_coef_mid),
        .i_coef_const  (i_coef_const),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_root_real   (o_root_real),
        .o_root_imag   (o_root_imag),
        .o_multiplicity(o_multiplicity),
        .o_root_kind   (o_root_kind),
        .o_status      (o_status),
        .o_last_root   (o_last_root)
    );

    qrs_root_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_poly_degree (i_poly_degree),
        .i_coef_lead   (i_coef_lead),
        .i_coef_mid    (i_coef_mid),
        .i_coef_const  (i_coef_const),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_root_real   (o_root_real),
        .i_root_imag   (o_root_imag),
        .i_multiplicity(o_multiplicity),
        .i_root_kind   (o_root_kind),
        .i_status      (o_status),
        .i_last_root   (o_last_root),
        .o_pending     (pending),
        .o_errors      (errors)
    );

    // Receiver: random stall, none while quiet, and one long hold-off on request
    // so the pipeline fills and pushes back on the input.
    always @(posedge i_clk) begin
        int hold_left;
        if (hold_req && !hold_armed) begin
            hold_armed = 1'b1;
            hold_left  = HOLD_LEN;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else if (quiet) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < 32);
        end
    end

    // Watchdog: count cycles in which no beat moves on either channel.
    always @(posedge i_clk) begin
        if (i_rst_n && ((i_valid && !o_stall) || (o_valid && !i_stall)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb failed");
            $finish;
        end
    end

    // Offer one polynomial, with random gaps in front unless quiet, and hold it until taken.
    // Stall only moves at the rising edge, so sample it at the falling edge.
    task automatic send_poly(logic [1:0] deg, logic [31:0] a, logic [31:0] b, logic [31:0] c);
        logic taken;
        if (!quiet) begin
            while ($urandom_range(99) < 32) begin
                i_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_valid       <= 1'b1;
        i_poly_degree <= deg;
        i_coef_lead   <= a;
        i_coef_mid    <= b;
        i_coef_const  <= c;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end
    endtask

    // Mix zeros, small values, extremes and full-range words.
    function automatic logic [31:0] rand_coef();
        case ($urandom_range(9))
            0:       return '0;
            1, 2:    return $urandom_range(1, 1 << 18) * ($urandom_range(1) ? 1 : -1);
            3: begin
                case ($urandom_range(3))
                    0:       return 32'h8000_0000;
                    1:       return 32'h7fff_ffff;
                    2:       return 32'h0000_0001;
                    default: return 32'hffff_ffff;
                endcase
            end
            default: return $urandom;
        endcase
    endfunction

    // Idle the input until every expected beat has come; read the count away
    // from the rising edge so the checker has settled it.
    task automatic wait_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        @(posedge i_clk);
    endtask

    localparam logic [31:0] ONE = 32'h0001_0000;

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: each degree, zero leading term, zero roots, every discriminant sign
        send_poly(2'd0, $urandom, $urandom, $urandom);
        send_poly(2'd1, '0, ONE, ONE);
        send_poly(2'd2, '0, ONE, ONE);
        send_poly(2'd1, ONE, '0, ONE);              // only a zero root
        send_poly(2'd2, ONE, '0, '0);               // double zero root
        send_poly(2'd2, ONE, -3 * ONE, '0);         // zero root plus linear
        send_poly(2'd1, 32'h0000_0001, 32'h7fff_ffff, '0); // linear, root just inside the range
        send_poly(2'd1, 32'h8000_0000, 32'h8000_0000, '0);
        send_poly(2'd1, -2 * ONE, 3 * ONE, '0);
        send_poly(2'd2, ONE, 2 * ONE, ONE);         // double root
        send_poly(2'd2, ONE, -3 * ONE, 2 * ONE);    // two real roots
        send_poly(2'd2, ONE, '0, -ONE);             // real roots with zero b
        send_poly(2'd2, ONE, '0, ONE);              // complex pair
        send_poly(2'd2, -ONE, 2 * ONE, -5 * ONE);
        send_poly(2'd3, ONE, -3 * ONE, 2 * ONE);    // degree three acts as two
        send_poly(2'd2, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_poly(2'd2, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_poly(2'd2, 32'h0000_0001, 32'h7fff_ffff, 32'h0000_0001); // one very large root, just inside the range
        send_poly(2'd2, 32'h0000_0001, 32'h8000_0000, 32'h7fff_ffff);
        send_poly(2'd2, 32'h0000_0001, 32'h0000_0001, 32'h7fff_ffff);
        send_poly(2'd2, 32'hffff_ffff, '0, 32'h8000_0000);
        wait_drained();

        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == 300)
                hold_req <= 1'b1;
            if (n == 310)
                hold_req <= 1'b0;
            quiet <= (n >= 700 && n < 900);
            if (n == 1000 || n == 1300)
                wait_drained();
            send_poly(2'($urandom_range(3)), rand_coef(), rand_coef(), rand_coef());
        end

        wait_drained();
        repeat (LATENCY + 20) @(posedge i_clk);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/qrs_pkg.sv
rtl/qrs_sqrt_pipe.sv
rtl/qrs_div_pipe.sv
rtl/quadratic_root_solver_core.sv
tb/qrs_root_checker.sv
tb/tb.sv
